### rtl/stftm_pkg.sv
// Shared types, constants and table builders for the spectrogram unit
`timescale 1ns / 1ps
`default_nettype none
package stftm_pkg;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [23:0] MAG_MAX     = 24'hFFFFFF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic [6:0]  bin_base;
        logic [23:0] mag0;
        logic [23:0] mag1;
        logic [23:0] mag2;
        logic [23:0] mag3;
        logic [2:0]  bins_valid;
        logic        frame_end;
        logic        stream_end;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END_CHECK,
        ST_WIN,
        ST_BIN_START,
        ST_BIN_WAIT,
        ST_PUSH
    } top_state_t;

    typedef enum logic [2:0] {
        DS_IDLE,
        DS_MAC,
        DS_ROUND,
        DS_SQRE,
        DS_SQIM,
        DS_ROOT
    } dft_state_t;

    typedef struct packed {
        logic signed [63:0] c;
        logic signed [63:0] s;
    } cs_t;

    function automatic cs_t quarter_cs(input logic [63:0] r_in);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] cv;
        logic [63:0] sv;
        logic        swap;
        cs_t         o;
        r    = r_in;
        swap = r > (Q30_ONE >> 1);
        if (swap)
        begin
            r = Q30_ONE - r;
        end
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 12;
        cv = Q30_ONE - ((x2 * t) >> 30) / 2;
        u  = Q30_ONE - x2 / 72;
        u  = Q30_ONE - ((x2 * u) >> 30) / 42;
        u  = Q30_ONE - ((x2 * u) >> 30) / 20;
        u  = Q30_ONE - ((x2 * u) >> 30) / 6;
        sv = (x * u) >> 30;
        o.c = swap ? $signed(sv) : $signed(cv);
        o.s = swap ? $signed(cv) : $signed(sv);
        return o;
    endfunction

    function automatic cs_t turn_cs(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [31:0] p;
        cs_t         qc;
        cs_t         o;
        num = {a, 32'd0};
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= {32'd0, b})
            begin
                rem    = rem - {32'd0, b};
                quo[i] = 1'b1;
            end
        end
        p  = quo[31:0];
        qc = quarter_cs({34'd0, p[29:0]});
        case (p[31:30])
            2'd0:
            begin
                o.c = qc.c;
                o.s = qc.s;
            end
            2'd1:
            begin
                o.c = -qc.s;
                o.s = qc.c;
            end
            2'd2:
            begin
                o.c = -qc.c;
                o.s = -qc.s;
            end
            default:
            begin
                o.c = qc.s;
                o.s = -qc.c;
            end
        endcase
        return o;
    endfunction

    function automatic logic signed [16:0] to_q15(input logic signed [63:0] v);
        logic [63:0] m;
        m = v < 0 ? 64'(-v) : 64'(v);
        m = (m + 64'd16384) >> 15;
        return v < 0 ? -$signed(m[16:0]) : $signed(m[16:0]);
    endfunction

    function automatic logic [15:0] win_coef(input int n, input int nw);
        cs_t                cs;
        logic signed [63:0] w;
        cs = turn_cs(32'(n), 32'(nw - 1));
        w  = (64'sd54 * $signed(Q30_ONE) - 64'sd46 * cs.c) / 64'sd100;
        w  = (w + 64'sd16384) >>> 15;
        return (w > 64'sd32767) ? 16'd32767 : w[15:0];
    endfunction

    function automatic logic signed [16:0] tw_cos(input int n, input int nw);
        cs_t cs;
        cs = turn_cs(32'(n), 32'(nw));
        return to_q15(cs.c);
    endfunction

    function automatic logic signed [16:0] tw_sin(input int n, input int nw);
        cs_t cs;
        cs = turn_cs(32'(n), 32'(nw));
        return to_q15(cs.s);
    endfunction

endpackage
`default_nettype wire

### rtl/stftm_if.sv
// Handshake channel interfaces for samples, results and configuration
`timescale 1ns / 1ps
`default_nettype none
interface stftm_sample_if;
    logic              valid;
    logic              ready;
    stftm_pkg::sample_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stftm_result_if;
    logic              valid;
    logic              ready;
    stftm_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stftm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] hop_size;
    modport source (output valid, output hop_size, input ready);
    modport sink (input valid, input hop_size, output ready);
endinterface
`default_nettype wire

### rtl/stftm_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module stftm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/stftm_sqrt.sv
// Bit-serial square root, rounded to nearest
`timescale 1ns / 1ps
`default_nettype none
module stftm_sqrt #(
    parameter int VW = 46
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [VW-1:0]   value,
    output logic                 done,
    output logic      [VW/2:0]   root
);

    localparam int JW = $clog2(VW / 2);
    localparam logic [JW-1:0] J_TOP = JW'(VW / 2 - 1);

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [JW-1:0] j_reg, j_next;
    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] res_reg, res_next;
    logic [VW/2:0] root_reg, root_next;
    logic [VW-1:0] bitv;
    logic [VW-1:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        j_next    = j_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        root_next = root_reg;
        bitv      = VW'(1) << {j_reg, 1'b0};
        trial     = res_reg + bitv;
        if (start)
        begin
            busy_next = 1'b1;
            j_next    = J_TOP;
            v_next    = value;
            res_next  = '0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bitv;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            if (j_reg == '0)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else
            begin
                j_next = j_reg - 1'b1;
            end
        end
        if (fin_reg)
        begin
            root_next = res_reg[VW/2:0] + (VW/2+1)'(v_reg > res_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

### rtl/stftm_dft.sv
// Per-bin DFT engine: multiply-accumulate over the work memory, then magnitude
`timescale 1ns / 1ps
`default_nettype none
module stftm_dft #(
    parameter int WINDOW = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [$clog2(WINDOW)-1:0]   k,
    output logic      [$clog2(WINDOW)-1:0]   rd_addr,
    input  wire logic signed [15:0]          rd_data,
    output logic                             done,
    output logic      [23:0]                 mag
);

    localparam int AW  = $clog2(WINDOW);
    localparam int HW  = AW + 1;
    localparam int ACW = AW + 32;
    localparam int RW  = AW + 17;
    localparam int SQW = 2 * AW + 32;
    localparam int RTW = SQW / 2 + 1;
    localparam logic [HW-1:0] N_H = HW'(WINDOW);

    typedef logic signed [16:0] tw_tab_t [WINDOW];

    function automatic tw_tab_t build_cos();
        tw_tab_t t;
        for (int n = 0; n < WINDOW; n++)
        begin
            t[n] = stftm_pkg::tw_cos(n, WINDOW);
        end
        return t;
    endfunction

    function automatic tw_tab_t build_sin();
        tw_tab_t t;
        for (int n = 0; n < WINDOW; n++)
        begin
            t[n] = stftm_pkg::tw_sin(n, WINDOW);
        end
        return t;
    endfunction

    localparam tw_tab_t COS_TAB = build_cos();
    localparam tw_tab_t SIN_TAB = build_sin();

    stftm_pkg::dft_state_t st_reg, st_next;
    logic [HW-1:0]          n_reg, n_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          k_reg, k_next;
    logic signed [16:0]     tc_reg, tc_next, ts_reg, ts_next;
    logic                   v1_reg, v1_next, v2_reg, v2_next;
    logic signed [32:0]     pr_reg, pr_next, pi_reg, pi_next;
    logic signed [ACW-1:0]  are_reg, are_next, aim_reg, aim_next;
    logic signed [RW-1:0]   r_reg, r_next, i_reg, i_next;
    logic [SQW-1:0]         sq_reg, sq_next;
    logic                   sqs_reg, sqs_next;
    logic                   done_reg, done_next;
    logic [23:0]            mag_reg, mag_next;
    logic [AW:0]            idx_sum;
    logic signed [ACW-1:0]  are_rnd, aim_rnd;
    logic signed [2*RW-1:0] sq_prod;
    logic                   sq_done;
    logic [RTW-1:0]         sq_root;
    logic [RTW+23:0]        root_wide;

    always_comb
    begin
        st_next   = st_reg;
        n_next    = n_reg;
        idx_next  = idx_reg;
        k_next    = k_reg;
        tc_next   = tc_reg;
        ts_next   = ts_reg;
        v1_next   = 1'b0;
        v2_next   = v1_reg;
        pr_next   = pr_reg;
        pi_next   = pi_reg;
        are_next  = are_reg;
        aim_next  = aim_reg;
        r_next    = r_reg;
        i_next    = i_reg;
        sq_next   = sq_reg;
        sqs_next  = 1'b0;
        done_next = 1'b0;
        mag_next  = mag_reg;
        rd_addr   = n_reg[AW-1:0];
        idx_sum   = {1'b0, idx_reg} + {1'b0, k_reg};
        if (idx_sum >= (AW+1)'(WINDOW))
        begin
            idx_sum = idx_sum - (AW+1)'(WINDOW);
        end
        are_rnd   = are_reg + ACW'(16384);
        aim_rnd   = aim_reg + ACW'(16384);
        sq_prod   = (st_reg == stftm_pkg::DS_SQRE) ? r_reg * r_reg : i_reg * i_reg;
        root_wide = (RTW+24)'(sq_root);

        if (v1_reg)
        begin
            pr_next = rd_data * tc_reg;
            pi_next = rd_data * ts_reg;
        end
        if (v2_reg)
        begin
            are_next = are_reg + ACW'(pr_reg);
            aim_next = aim_reg + ACW'(pi_reg);
        end

        unique case (st_reg)
            stftm_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    k_next   = k;
                    n_next   = '0;
                    idx_next = '0;
                    are_next = '0;
                    aim_next = '0;
                    st_next  = stftm_pkg::DS_MAC;
                end
            end
            stftm_pkg::DS_MAC:
            begin
                if (n_reg != N_H)
                begin
                    tc_next  = COS_TAB[idx_reg];
                    ts_next  = SIN_TAB[idx_reg];
                    v1_next  = 1'b1;
                    n_next   = n_reg + 1'b1;
                    idx_next = idx_sum[AW-1:0];
                end
                else if (!v1_reg && !v2_reg)
                begin
                    st_next = stftm_pkg::DS_ROUND;
                end
            end
            stftm_pkg::DS_ROUND:
            begin
                r_next  = are_rnd[ACW-1:15];
                i_next  = aim_rnd[ACW-1:15];
                st_next = stftm_pkg::DS_SQRE;
            end
            stftm_pkg::DS_SQRE:
            begin
                sq_next = SQW'(sq_prod);
                st_next = stftm_pkg::DS_SQIM;
            end
            stftm_pkg::DS_SQIM:
            begin
                sq_next  = sq_reg + SQW'(sq_prod);
                sqs_next = 1'b1;
                st_next  = stftm_pkg::DS_ROOT;
            end
            stftm_pkg::DS_ROOT:
            begin
                if (sq_done)
                begin
                    mag_next  = (root_wide > (RTW+24)'(stftm_pkg::MAG_MAX)) ?
                                stftm_pkg::MAG_MAX : root_wide[23:0];
                    done_next = 1'b1;
                    st_next   = stftm_pkg::DS_IDLE;
                end
            end
            default:
            begin
                st_next = stftm_pkg::DS_IDLE;
            end
        endcase
    end

    stftm_sqrt #(.VW(SQW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqs_reg),
        .value (sq_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= stftm_pkg::DS_IDLE;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sqs_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            sqs_reg  <= sqs_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        idx_reg <= idx_next;
        k_reg   <= k_next;
        tc_reg  <= tc_next;
        ts_reg  <= ts_next;
        pr_reg  <= pr_next;
        pi_reg  <= pi_next;
        are_reg <= are_next;
        aim_reg <= aim_next;
        r_reg   <= r_next;
        i_reg   <= i_next;
        sq_reg  <= sq_next;
        mag_reg <= mag_next;
    end

    assign done = done_reg;
    assign mag  = mag_reg;

endmodule
`default_nettype wire

### rtl/stft_magnitude_spectrogram_unit.sv
// Top level of the Hamming-windowed short-time spectrum magnitude unit
`timescale 1ns / 1ps
`default_nettype none
// A sample is taken whenever no frame is being analysed. When a frame
// completes, input stalls while the frame is windowed into the work memory
// and each of the WINDOW/2+1 bins is computed by one multiply-accumulate
// unit that reads the work memory once per cycle, followed by rounding,
// squaring and a bit-serial square root. Results leave up to four bins per
// item through an output register; a result not taken holds the engine
// before the next group. No clearing pass is run.
module stft_magnitude_spectrogram_unit #(
    parameter int WINDOW = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    stftm_sample_if.sink     samples,
    stftm_cfg_if.sink        cfg,
    stftm_result_if.source   spectra
);

    localparam int AW = $clog2(WINDOW);
    localparam int HW = AW + 1;
    localparam logic [HW-1:0] N_H    = HW'(WINDOW);
    localparam logic [31:0]   N_W    = 32'(WINDOW);
    localparam logic [AW-1:0] HALF_K = AW'(WINDOW / 2);
    localparam logic [AW-1:0] LAST_A = AW'(WINDOW - 1);

    typedef logic [15:0] win_tab_t [WINDOW];

    function automatic win_tab_t build_win();
        win_tab_t t;
        for (int n = 0; n < WINDOW; n++)
        begin
            t[n] = stftm_pkg::win_coef(n, WINDOW);
        end
        return t;
    endfunction

    localparam win_tab_t WIN_TAB = build_win();

    function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
        return (p == LAST_A) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] frame_base(input logic [AW-1:0] p,
                                                 input logic [HW-1:0] have);
        logic [HW:0] s;
        s = {2'b00, p} + (HW+1)'(WINDOW) - {1'b0, have};
        if (s >= (HW+1)'(WINDOW))
        begin
            s = s - (HW+1)'(WINDOW);
        end
        return s[AW-1:0];
    endfunction

    stftm_pkg::top_state_t state_reg, state_next;
    logic [7:0]         hop_reg, hop_next;
    logic [31:0]        seen_reg, seen_next;
    logic [31:0]        nfs_reg, nfs_next;
    logic               stopped_reg, stopped_next;
    logic [AW-1:0]      ring_pos_reg, ring_pos_next;
    logic               last_reg, last_next;
    logic               end_flag_reg, end_flag_next;
    logic               frame_b_reg, frame_b_next;
    logic [HW-1:0]      have_reg, have_next;
    logic [HW-1:0]      wi_reg, wi_next;
    logic [AW-1:0]      raddr_reg, raddr_next;
    logic [15:0]        coef_reg, coef_next;
    logic               keep_reg, keep_next;
    logic [AW-1:0]      widx_reg, widx_next;
    logic               wv_reg, wv_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [23:0]        mag_reg [4];
    logic [23:0]        mag_next [4];
    logic               out_valid_reg, out_valid_next;
    stftm_pkg::result_t out_data_reg, out_data_next;

    logic               accept;
    logic               last_in;
    logic [31:0]        seen_inc;
    logic [31:0]        d_acc;
    logic [31:0]        d_end;
    logic [7:0]         hop_eff;
    logic               pad;
    logic               ring_we;
    logic [15:0]        ring_rdata;
    logic signed [32:0] wprod;
    logic signed [32:0] wround;
    logic [15:0]        wy;
    logic [15:0]        fw_rdata;
    logic [AW-1:0]      fw_raddr;
    logic               dft_start;
    logic               dft_done;
    logic [23:0]        dft_mag;
    logic               group_full;

    assign samples.ready = (state_reg == stftm_pkg::ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign spectra.valid = out_valid_reg;
    assign spectra.data  = out_data_reg;

    assign accept   = samples.valid && samples.ready;
    assign last_in  = samples.data.last_sample;
    assign seen_inc = seen_reg + 32'd1;
    assign d_acc    = seen_inc - nfs_reg;
    assign d_end    = seen_reg - nfs_reg;
    assign hop_eff  = (hop_reg == 8'd0) ? 8'd1 : hop_reg;
    assign pad      = last_in && ({24'd0, hop_eff} < N_W);
    assign wprod    = $signed(ring_rdata) * $signed({1'b0, coef_reg});
    assign wround   = wprod + 33'sd16384;
    assign wy       = keep_reg ? wround[30:15] : 16'd0;
    assign group_full = (k_reg[1:0] == 2'd3) || (k_reg == HALF_K);

    always_comb
    begin
        state_next     = state_reg;
        hop_next       = (cfg.valid && cfg.ready) ? cfg.hop_size : hop_reg;
        seen_next      = seen_reg;
        nfs_next       = nfs_reg;
        stopped_next   = stopped_reg;
        ring_pos_next  = ring_pos_reg;
        last_next      = last_reg;
        end_flag_next  = end_flag_reg;
        frame_b_next   = frame_b_reg;
        have_next      = have_reg;
        wi_next        = wi_reg;
        raddr_next     = raddr_reg;
        coef_next      = coef_reg;
        keep_next      = keep_reg;
        widx_next      = widx_reg;
        wv_next        = 1'b0;
        k_next         = k_reg;
        mag_next       = mag_reg;
        out_valid_next = (out_valid_reg && spectra.ready) ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        ring_we        = 1'b0;
        dft_start      = 1'b0;

        unique case (state_reg)
            stftm_pkg::ST_IDLE:
            begin
                if (accept && !stopped_reg)
                begin
                    ring_we       = 1'b1;
                    ring_pos_next = pos_inc(ring_pos_reg);
                    seen_next     = seen_inc;
                    stopped_next  = last_in;
                    last_next     = last_in;
                    if (d_acc == N_W)
                    begin
                        nfs_next      = nfs_reg + {24'd0, hop_eff};
                        have_next     = N_H;
                        end_flag_next = last_in && !pad;
                        frame_b_next  = 1'b0;
                        raddr_next    = pos_inc(ring_pos_reg);
                        wi_next       = '0;
                        state_next    = stftm_pkg::ST_WIN;
                    end
                    else if (last_in)
                    begin
                        state_next = stftm_pkg::ST_END_CHECK;
                    end
                end
            end
            stftm_pkg::ST_END_CHECK:
            begin
                if (d_end != 32'd0 && d_end < N_W)
                begin
                    have_next     = d_end[HW-1:0];
                    end_flag_next = 1'b1;
                    frame_b_next  = 1'b1;
                    raddr_next    = frame_base(ring_pos_reg, d_end[HW-1:0]);
                    wi_next       = '0;
                    state_next    = stftm_pkg::ST_WIN;
                end
                else
                begin
                    state_next = stftm_pkg::ST_IDLE;
                end
            end
            stftm_pkg::ST_WIN:
            begin
                if (wi_reg != N_H)
                begin
                    wv_next    = 1'b1;
                    widx_next  = wi_reg[AW-1:0];
                    coef_next  = WIN_TAB[wi_reg[AW-1:0]];
                    keep_next  = wi_reg < have_reg;
                    raddr_next = pos_inc(raddr_reg);
                    wi_next    = wi_reg + 1'b1;
                end
                else
                begin
                    k_next     = '0;
                    mag_next   = '{default: '0};
                    state_next = stftm_pkg::ST_BIN_START;
                end
            end
            stftm_pkg::ST_BIN_START:
            begin
                dft_start  = 1'b1;
                state_next = stftm_pkg::ST_BIN_WAIT;
            end
            stftm_pkg::ST_BIN_WAIT:
            begin
                if (dft_done)
                begin
                    mag_next[k_reg[1:0]] = dft_mag;
                    if (group_full)
                    begin
                        state_next = stftm_pkg::ST_PUSH;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = stftm_pkg::ST_BIN_START;
                    end
                end
            end
            stftm_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || spectra.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.bin_base   = 7'({k_reg[AW-1:2], 2'b00});
                    out_data_next.mag0       = mag_reg[0];
                    out_data_next.mag1       = mag_reg[1];
                    out_data_next.mag2       = mag_reg[2];
                    out_data_next.mag3       = mag_reg[3];
                    out_data_next.bins_valid = {1'b0, k_reg[1:0]} + 3'd1;
                    out_data_next.frame_end  = (k_reg == HALF_K);
                    out_data_next.stream_end = (k_reg == HALF_K) && end_flag_reg;
                    mag_next                 = '{default: '0};
                    if (k_reg == HALF_K)
                    begin
                        if (!frame_b_reg && last_reg)
                        begin
                            state_next = stftm_pkg::ST_END_CHECK;
                        end
                        else
                        begin
                            state_next = stftm_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = stftm_pkg::ST_BIN_START;
                    end
                end
            end
            default:
            begin
                state_next = stftm_pkg::ST_IDLE;
            end
        endcase
    end

    stftm_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_pos_reg),
        .wdata (samples.data.sample),
        .raddr (raddr_reg),
        .rdata (ring_rdata)
    );

    stftm_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_work (
        .clk   (clk),
        .we    (wv_reg),
        .waddr (widx_reg),
        .wdata (wy),
        .raddr (fw_raddr),
        .rdata (fw_rdata)
    );

    stftm_dft #(.WINDOW(WINDOW)) u_dft (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dft_start),
        .k       (k_reg),
        .rd_addr (fw_raddr),
        .rd_data (fw_rdata),
        .done    (dft_done),
        .mag     (dft_mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stftm_pkg::ST_IDLE;
            hop_reg       <= 8'd32;
            seen_reg      <= '0;
            nfs_reg       <= '0;
            stopped_reg   <= 1'b0;
            ring_pos_reg  <= '0;
            last_reg      <= 1'b0;
            end_flag_reg  <= 1'b0;
            frame_b_reg   <= 1'b0;
            wi_reg        <= '0;
            wv_reg        <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hop_reg       <= hop_next;
            seen_reg      <= seen_next;
            nfs_reg       <= nfs_next;
            stopped_reg   <= stopped_next;
            ring_pos_reg  <= ring_pos_next;
            last_reg      <= last_next;
            end_flag_reg  <= end_flag_next;
            frame_b_reg   <= frame_b_next;
            wi_reg        <= wi_next;
            wv_reg        <= wv_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        have_reg     <= have_next;
        raddr_reg    <= raddr_next;
        coef_reg     <= coef_next;
        keep_reg     <= keep_next;
        widx_reg     <= widx_next;
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
    end

    a_stream_end_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (spectra.valid && spectra.data.stream_end) |-> spectra.data.frame_end)
        else $error("stream end without frame end");

    a_stopped_ignores_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stopped_reg) |=> (seen_reg == $past(seen_reg)))
        else $error("sample taken after stream end");

    a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        dft_done |-> (state_reg == stftm_pkg::ST_BIN_WAIT))
        else $error("bin result outside wait state");

endmodule
`default_nettype wire
